// File: hw/rtl/ita_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_pkg
// Shared constants, command/status structs and the digit-to-ASCII mapping
// for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 5;
  localparam int CHAR_W      = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_LC_A  = 8'h61;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 5'd10;

  // Long division by the radix, DIV_BITS dividend bits per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W      = DIV_CYCLES * DIV_BITS;
  localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Digit store: base two gives the most digits, one per value bit
  localparam int DIG_DEPTH = VALUE_WIDTH;
  localparam int DIG_AW    = $clog2(DIG_DEPTH);
  localparam int CNT_W     = $clog2(DIG_DEPTH + 1);

  typedef struct packed {
    logic load;        // latch value, radix; clear digit count
    logic div_step;    // one division cycle
    logic div_last;    // final division cycle: store the digit
    logic rd_first;    // fetch most significant digit
    logic rd_next;     // fetch next lower digit
    logic emit_sign;   // drive '-'
    logic emit_digit;  // drive fetched digit
  } ita_cmd_t;

  typedef struct packed {
    logic neg;         // value is negative
    logic quot_zero;   // quotient after this division cycle is zero
    logic rd_last;     // fetched digit is the least significant one
  } ita_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DEC_DIGITS) begin
      digit_to_ascii = ASCII_ZERO + dx;
    end else begin
      digit_to_ascii = ASCII_LC_A + dx - CHAR_W'(DEC_DIGITS);
    end
  endfunction

endpackage

// File: hw/rtl/ita_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_ctrl
// Sequencer: runs the digit divisions, then steps out sign and digits.
// ----------------------------------------------------------------------------
module ita_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ita_pkg::ita_stat_t stat_i,
  output ita_pkg::ita_cmd_t  cmd_o,
  output logic               char_strobe_o
);
  import ita_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_CYCLES - 1)) begin
          cmd_o.div_last = 1'b1;
          step_d         = '0;
          if (stat_i.quot_zero) begin
            state_d = ST_PREP;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_PREP: begin
        cmd_o.rd_first = 1'b1;
        state_d        = stat_i.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        if (stat_i.rd_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign char_strobe_o = cmd_o.emit_sign | cmd_o.emit_digit;

endmodule

// File: hw/rtl/ita_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_dpath
// Radix register, magnitude/sign capture, radix divider, digit store and
// character output mux.
// ----------------------------------------------------------------------------
module ita_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 radix_we_i,
  input  logic        [ita_pkg::RADIX_W-1:0]   radix_wdata_i,
  input  logic signed [ita_pkg::VALUE_WIDTH-1:0] value_i,
  input  ita_pkg::ita_cmd_t                    cmd_i,
  output ita_pkg::ita_stat_t                   stat_o,
  output logic        [ita_pkg::CHAR_W-1:0]    char_code_o,
  output logic                                 last_char_o
);
  import ita_pkg::*;

  logic [RADIX_W-1:0]     radix_q;
  logic [RADIX_W-1:0]     base_q;
  logic                   neg_q;
  logic [DIV_W-1:0]       quot_q, quot_d;
  logic [RADIX_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q;
  logic [DIG_AW-1:0]      rd_ptr_q, rd_addr;
  logic [RADIX_W-1:0]     rdata_q;
  logic [RADIX_W-1:0]     dig_mem [DIG_DEPTH];

  logic [VALUE_WIDTH-1:0] v_raw, mag;
  logic [RADIX_W-1:0]     base_eff;

  assign v_raw    = value_i;
  assign mag      = v_raw[VALUE_WIDTH-1] ? (~v_raw + 1'b1) : v_raw;
  assign base_eff = (radix_q < RADIX_MIN) ? RADIX_DEFAULT : radix_q;

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [RADIX_W:0]     trial;
    logic [RADIX_W-1:0]   r;
    logic [DIV_BITS-1:0]  chunk;
    logic [DIV_BITS-1:0]  qb;
    r     = rem_q;
    chunk = quot_q[DIV_W-1 -: DIV_BITS];
    qb    = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {r, chunk[i]};
      if (trial >= {1'b0, base_q}) begin
        trial = trial - {1'b0, base_q};
        qb[i] = 1'b1;
      end
      r = trial[RADIX_W-1:0];
    end
    rem_d  = r;
    quot_d = (quot_q << DIV_BITS) | DIV_W'(qb);
  end

  assign rd_addr = cmd_i.rd_first ? DIG_AW'(cnt_q - CNT_W'(1)) : (rd_ptr_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (radix_we_i) begin
      radix_q <= radix_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_eff;
      neg_q  <= v_raw[VALUE_WIDTH-1];
      quot_q <= DIV_W'(mag);
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_d;
      if (cmd_i.div_last) begin
        rem_q <= '0;
        cnt_q <= cnt_q + 1'b1;
      end else begin
        rem_q <= rem_d;
      end
    end
    if (cmd_i.rd_first || cmd_i.rd_next) begin
      rd_ptr_q <= rd_addr;
    end
  end

  // Digit store, least significant digit at address zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && cmd_i.div_last) begin
      dig_mem[cnt_q[DIG_AW-1:0]] <= rem_d;
    end
    if (cmd_i.rd_first || cmd_i.rd_next) begin
      rdata_q <= dig_mem[rd_addr];
    end
  end

  assign stat_o.neg       = neg_q;
  assign stat_o.quot_zero = (quot_d == '0);
  assign stat_o.rd_last   = (rd_ptr_q == '0);

  assign char_code_o = cmd_i.emit_sign ? ASCII_MINUS : digit_to_ascii(rdata_q);
  assign last_char_o = cmd_i.emit_digit & (rd_ptr_q == '0);

endmodule

// File: hw/rtl/int_to_radix_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_radix_ascii_top
// Signed integer to ASCII text in a programmable radix, one character word
// per strobe, sign first, most significant digit next, last word flagged.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Dir  Handshake
//  -------   -------------------------------  ---  ---------------------------
//  input     start, busy, value_i             in   word taken: start & !busy
//  output    char_strobe_o, char_code_o,      out  one word per strobe cycle,
//            last_char_o                           no back-pressure
//  config    radix_we_i, radix_wdata_i        in   written on radix_we_i
//
//  Sequence: for each digit the radix divider takes 8 dividend bits a
//  cycle; then the most significant digit is fetched from the digit
//  store, the sign word is sent for a negative value, and one word
//  per cycle follows for each digit. Busy stays high throughout, so
//  no new value is taken until the last word is strobed.
//  Reset: asynchronous, active low; sequencer idles, radix returns to ten.
//  Stalls: none; the receiver must take every word as it is strobed.
//
module int_to_radix_ascii_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input word
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ita_pkg::VALUE_WIDTH-1:0] value_i,
  // radix register
  input  logic                                   radix_we_i,
  input  logic        [ita_pkg::RADIX_W-1:0]     radix_wdata_i,
  // character words
  output logic                                   char_strobe_o,
  output logic        [ita_pkg::CHAR_W-1:0]      char_code_o,
  output logic                                   last_char_o
);
  import ita_pkg::*;

  ita_cmd_t  cmd;
  ita_stat_t stat;

  // Sequencer: accept, per-digit division loop, fetch, sign, digits
  ita_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .char_strobe_o (char_strobe_o)
  );

  // Datapath: divider leaves digits low-first in the store, read back high-first
  ita_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radix_we_i    (radix_we_i),
    .radix_wdata_i (radix_wdata_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .char_code_o   (char_code_o),
    .last_char_o   (last_char_o)
  );

endmodule
